>>> hdl/lfs_pkg.sv
// shared types and constants for the latched fault supervisor
`default_nettype none

package lfs_pkg;

    // field widths
    localparam int NUM_CH     = 4;
    localparam int VAL_W      = 16;
    localparam int CNT_W      = 4;
    localparam int DELAY_W    = 9;
    localparam int BLINK_W    = 8;
    localparam int HIGH_RUN_W = 2;
    localparam int LOW_RUN_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 16;
    localparam int RESULT_W   = 9;

    // debounced channel positions in the raw pin field
    localparam int CH_MAINT   = 0;
    localparam int CH_RUNNING = 1;
    localparam int CH_OVERCUR = 2;
    localparam int CH_WATER   = 3;

    // phase loss run lengths and blink intervals in ticks
    localparam logic [HIGH_RUN_W-1:0] PHASE_SET_RUN   = 2'd2;
    localparam logic [LOW_RUN_W-1:0]  PHASE_CLEAR_RUN = 6'd40;
    localparam logic [BLINK_W-1:0]    BLINK_FAULT     = 8'd100;
    localparam logic [BLINK_W-1:0]    BLINK_NORMAL    = 8'd200;

    // configuration defaults
    localparam logic [CNT_W-1:0]   STABLE_RESET = 4'd10;
    localparam logic [DELAY_W-1:0] DELAY_RESET  = 9'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLT_LOW     = 3'd0,
        REG_VOLT_HIGH    = 3'd1,
        REG_FREQ_LOW     = 3'd2,
        REG_FREQ_HIGH    = 3'd3,
        REG_TEMP_LOW     = 3'd4,
        REG_TEMP_HIGH    = 3'd5,
        REG_STABLE_COUNT = 3'd6,
        REG_START_DELAY  = 3'd7
    } t_reg_index;

    // debounced levels after this tick's sample
    typedef struct packed {
        logic water_lack;
        logic over_current;
        logic running;
        logic maintenance;
    } t_levels;

    // one result item, last field in the lowest bit
    typedef struct packed {
        logic device_running;
        logic run_led;
        logic any_fault;
        logic freq_alarm;
        logic volt_alarm;
        logic phase_loss_alarm;
        logic water_temp_alarm;
        logic water_press_alarm;
        logic over_current_alarm;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/lfs_debounce_lane.sv
// one debounce lane: counts differing samples and takes a new level
`default_nettype none

module lfs_debounce_lane
    import lfs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_seeded,
    input  wire logic             i_sample,
    input  wire logic [CNT_W-1:0] i_stable_count,
    output logic                  o_level_next
);

    logic             r_level;
    logic [CNT_W-1:0] r_count;
    logic             n_level;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_count_inc;

    // saturating count of differing samples
    assign w_count_inc = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + 1'b1;

    // next level and count for this sample
    always_comb begin
        n_level = r_level;
        n_count = r_count;
        if (!i_seeded) begin
            n_level = i_sample;
            n_count = '0;
        end else if (i_sample == r_level) begin
            n_count = '0;
        end else if (w_count_inc >= i_stable_count) begin
            n_level = i_sample;
            n_count = '0;
        end else begin
            n_count = w_count_inc;
        end
    end

    assign o_level_next = n_level;

    // lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_count <= '0;
        end else if (i_advance) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lfs_limit_lane.sv
// one limit lane: reading against a lower and upper limit, zero disables
`default_nettype none

module lfs_limit_lane
    import lfs_pkg::*;
(
    input  wire logic [VAL_W-1:0] i_value,
    input  wire logic [VAL_W-1:0] i_low,
    input  wire logic [VAL_W-1:0] i_high,
    output logic                  o_outside
);

    logic w_below;
    logic w_above;

    // each limit only counts when it is nonzero
    assign w_below   = (i_low != '0) && (i_value < i_low);
    assign w_above   = (i_high != '0) && (i_value > i_high);
    assign o_outside = w_below || w_above;

endmodule

`default_nettype wire

>>> hdl/lfs_fault_core.sv
// merge stage: phase capture, fault latches, start timer and run led
`default_nettype none

module lfs_fault_core
    import lfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire t_levels            i_levels,
    input  wire logic               i_phase_raw,
    input  wire logic               i_debug_mode,
    input  wire logic               i_fault_reset,
    input  wire logic               i_start_request,
    input  wire logic               i_volt_bad,
    input  wire logic               i_freq_bad,
    input  wire logic               i_temp_bad,
    input  wire logic [DELAY_W-1:0] i_start_delay,
    output logic                    o_seeded,
    output t_result                 o_result
);

    logic                  r_seeded;
    logic [HIGH_RUN_W-1:0] r_high_run;
    logic [LOW_RUN_W-1:0]  r_low_run;
    logic                  r_phase_active;
    t_result               r_latch;
    logic                  r_total;
    logic                  r_running;
    logic                  r_last_start;
    logic [DELAY_W-1:0]    r_start_elapsed;
    logic [BLINK_W-1:0]    r_blink_elapsed;
    logic                  r_led;

    logic [HIGH_RUN_W-1:0] n_high_run;
    logic [LOW_RUN_W-1:0]  n_low_run;
    logic                  n_phase_active;
    t_result               n_latch;
    logic                  n_total;
    logic                  n_running;
    logic                  n_last_start;
    logic [DELAY_W-1:0]    n_start_elapsed;
    logic [BLINK_W-1:0]    n_blink_elapsed;
    logic                  n_led;

    logic                  w_masked;
    logic                  w_check_armed;
    logic [DELAY_W-1:0]    w_start_base;
    logic [BLINK_W-1:0]    w_blink_base;
    logic [BLINK_W-1:0]    w_interval;

    // phase loss capture with saturating run counters
    always_comb begin
        n_high_run     = r_high_run;
        n_low_run      = r_low_run;
        n_phase_active = r_phase_active;
        if (!r_seeded) begin
            n_phase_active = i_phase_raw;
        end else if (i_phase_raw) begin
            if (r_high_run != {HIGH_RUN_W{1'b1}}) begin
                n_high_run = r_high_run + 1'b1;
            end
            if (n_high_run >= PHASE_SET_RUN) begin
                n_phase_active = 1'b1;
            end
            n_low_run = '0;
        end else begin
            if (r_low_run != {LOW_RUN_W{1'b1}}) begin
                n_low_run = r_low_run + 1'b1;
            end
            if (n_low_run >= PHASE_CLEAR_RUN) begin
                n_phase_active = 1'b0;
            end
            n_high_run = '0;
        end
    end

    // maintenance pin is active low
    assign w_masked = i_debug_mode || !i_levels.maintenance;

    // fault latches, start edge timer and total fault
    always_comb begin
        n_latch       = r_latch;
        n_total       = r_total;
        n_running     = r_running;
        n_last_start  = r_last_start;
        w_start_base  = r_start_elapsed;
        w_check_armed = 1'b0;
        if (w_masked) begin
            n_latch = '0;
            n_total = 1'b0;
        end else begin
            if (i_fault_reset) begin
                n_latch = '0;
            end
            n_running = i_levels.running;
            if (i_start_request && !r_last_start) begin
                w_start_base = '0;
            end
            n_last_start  = i_start_request;
            w_check_armed = i_start_request && (w_start_base >= i_start_delay);
            if (w_check_armed && i_volt_bad) begin
                n_latch.volt_alarm = 1'b1;
            end
            if (w_check_armed && i_freq_bad) begin
                n_latch.freq_alarm = 1'b1;
            end
            if (i_temp_bad) begin
                n_latch.water_temp_alarm = 1'b1;
            end
            if (i_levels.over_current) begin
                n_latch.over_current_alarm = 1'b1;
            end
            if (i_levels.water_lack) begin
                n_latch.water_press_alarm = 1'b1;
            end
            if (n_phase_active) begin
                n_latch.phase_loss_alarm = 1'b1;
            end
            n_total = n_latch.over_current_alarm || n_latch.water_press_alarm
                   || n_latch.water_temp_alarm   || n_latch.phase_loss_alarm
                   || n_latch.volt_alarm         || n_latch.freq_alarm;
        end
    end

    // run led toggles on the interval that the total fault selects
    assign w_interval = n_total ? BLINK_FAULT : BLINK_NORMAL;

    always_comb begin
        w_blink_base = r_blink_elapsed;
        n_led        = r_led;
        if (r_blink_elapsed >= w_interval) begin
            w_blink_base = '0;
            n_led        = !r_led;
        end
    end

    // elapsed counters advance every tick and saturate
    assign n_blink_elapsed = (w_blink_base == {BLINK_W{1'b1}}) ? w_blink_base
                                                               : w_blink_base + 1'b1;
    assign n_start_elapsed = (w_start_base == {DELAY_W{1'b1}}) ? w_start_base
                                                               : w_start_base + 1'b1;

    // result of this tick
    always_comb begin
        o_result                = n_latch;
        o_result.any_fault      = n_total;
        o_result.run_led        = n_led;
        o_result.device_running = n_running;
    end

    assign o_seeded = r_seeded;

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded        <= 1'b0;
            r_high_run      <= '0;
            r_low_run       <= '0;
            r_phase_active  <= 1'b0;
            r_latch         <= '0;
            r_total         <= 1'b0;
            r_running       <= 1'b0;
            r_last_start    <= 1'b0;
            r_start_elapsed <= '0;
            r_blink_elapsed <= '0;
            r_led           <= 1'b0;
        end else if (i_advance) begin
            r_seeded        <= 1'b1;
            r_high_run      <= n_high_run;
            r_low_run       <= n_low_run;
            r_phase_active  <= n_phase_active;
            r_latch         <= n_latch;
            r_total         <= n_total;
            r_running       <= n_running;
            r_last_start    <= n_last_start;
            r_start_elapsed <= n_start_elapsed;
            r_blink_elapsed <= n_blink_elapsed;
            r_led           <= n_led;
        end
    end

endmodule

`default_nettype wire

>>> hdl/latched_fault_supervisor.sv
// a result is registered in the output register, or in the skid register while the output stalls
// throughput: one sample tick per clock while s_axis_tready is high, the state update is a single stage
// an output register plus a skid register let input flow while a result waits
// the input side stalls only when both output registers hold untaken results
// reset (i_rst_n low, synchronous) clears all tick state and loads default limits
`default_nettype none

module latched_fault_supervisor
    import lfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [VAL_W-1:0]      i_cfg_data,
    // sample stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // raw_channels, phase_raw, debug_mode, fault_reset, start_request, dc_voltage,
    // work_freq, temp_one, temp_two, temp_three, temp_four
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // over_current_alarm, water_press_alarm, water_temp_alarm, phase_loss_alarm,
    // volt_alarm, freq_alarm, any_fault, run_led, device_running, zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [VAL_W-1:0]   r_volt_low;
    logic [VAL_W-1:0]   r_volt_high;
    logic [VAL_W-1:0]   r_freq_low;
    logic [VAL_W-1:0]   r_freq_high;
    logic [VAL_W-1:0]   r_temp_low;
    logic [VAL_W-1:0]   r_temp_high;
    logic [CNT_W-1:0]   r_stable_count;
    logic [DELAY_W-1:0] r_start_delay;

    logic [NUM_CH-1:0]  w_raw;
    logic               w_phase_raw;
    logic               w_debug_mode;
    logic               w_fault_reset;
    logic               w_start_request;
    logic [VAL_W-1:0]   w_volt;
    logic [VAL_W-1:0]   w_freq;
    logic [VAL_W-1:0]   w_temp [NUM_CH];

    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_seeded;
    logic [NUM_CH-1:0]  w_level_next;
    logic [NUM_CH-1:0]  w_temp_bad;
    logic               w_volt_bad;
    logic               w_freq_bad;
    t_levels            w_levels;
    t_result            w_result;

    t_result            r_out;
    logic               r_out_valid;
    t_result            r_skid;
    logic               r_skid_valid;

    // unpack the sample
    assign w_raw           = s_axis_tdata[3:0];
    assign w_phase_raw     = s_axis_tdata[4];
    assign w_debug_mode    = s_axis_tdata[5];
    assign w_fault_reset   = s_axis_tdata[6];
    assign w_start_request = s_axis_tdata[7];
    assign w_volt          = s_axis_tdata[23:8];
    assign w_freq          = s_axis_tdata[39:24];
    assign w_temp[0]       = s_axis_tdata[55:40];
    assign w_temp[1]       = s_axis_tdata[71:56];
    assign w_temp[2]       = s_axis_tdata[87:72];
    assign w_temp[3]       = s_axis_tdata[103:88];

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = r_out_valid && m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_low     <= '0;
            r_volt_high    <= '0;
            r_freq_low     <= '0;
            r_freq_high    <= '0;
            r_temp_low     <= '0;
            r_temp_high    <= '0;
            r_stable_count <= STABLE_RESET;
            r_start_delay  <= DELAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_VOLT_LOW:     r_volt_low     <= i_cfg_data;
                REG_VOLT_HIGH:    r_volt_high    <= i_cfg_data;
                REG_FREQ_LOW:     r_freq_low     <= i_cfg_data;
                REG_FREQ_HIGH:    r_freq_high    <= i_cfg_data;
                REG_TEMP_LOW:     r_temp_low     <= i_cfg_data;
                REG_TEMP_HIGH:    r_temp_high    <= i_cfg_data;
                REG_STABLE_COUNT: r_stable_count <= i_cfg_data[CNT_W-1:0];
                REG_START_DELAY:  r_start_delay  <= i_cfg_data[DELAY_W-1:0];
            endcase
        end
    end

    // debounce lanes, one per raw channel
    for (genvar g = 0; g < NUM_CH; g++) begin : g_debounce
        lfs_debounce_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_advance      (w_in_xfer),
            .i_seeded       (w_seeded),
            .i_sample       (w_raw[g]),
            .i_stable_count (r_stable_count),
            .o_level_next   (w_level_next[g])
        );
    end

    assign w_levels.maintenance  = w_level_next[CH_MAINT];
    assign w_levels.running      = w_level_next[CH_RUNNING];
    assign w_levels.over_current = w_level_next[CH_OVERCUR];
    assign w_levels.water_lack   = w_level_next[CH_WATER];

    // temperature limit lanes
    for (genvar g = 0; g < NUM_CH; g++) begin : g_temp
        lfs_limit_lane u_lane (
            .i_value   (w_temp[g]),
            .i_low     (r_temp_low),
            .i_high    (r_temp_high),
            .o_outside (w_temp_bad[g])
        );
    end

    // voltage and frequency limit lanes
    lfs_limit_lane u_volt_lane (
        .i_value   (w_volt),
        .i_low     (r_volt_low),
        .i_high    (r_volt_high),
        .o_outside (w_volt_bad)
    );

    lfs_limit_lane u_freq_lane (
        .i_value   (w_freq),
        .i_low     (r_freq_low),
        .i_high    (r_freq_high),
        .o_outside (w_freq_bad)
    );

    // merge stage
    lfs_fault_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_in_xfer),
        .i_levels        (w_levels),
        .i_phase_raw     (w_phase_raw),
        .i_debug_mode    (w_debug_mode),
        .i_fault_reset   (w_fault_reset),
        .i_start_request (w_start_request),
        .i_volt_bad      (w_volt_bad),
        .i_freq_bad      (w_freq_bad),
        .i_temp_bad      (|w_temp_bad),
        .i_start_delay   (r_start_delay),
        .o_seeded        (w_seeded),
        .o_result        (w_result)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_xfer;
            end
        end else if (w_in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_xfer) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (w_in_xfer && r_out_valid && !w_out_xfer) begin
            r_skid <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, r_out};

`ifndef SYNTHESIS
    // the skid register only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // a transfer in while the output stalls must land in the skid register
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("input transfer during stall was not kept");

    // total fault only with at least one latched alarm
    a_total_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.any_fault) |->
            (r_out.over_current_alarm || r_out.water_press_alarm
             || r_out.water_temp_alarm || r_out.phase_loss_alarm
             || r_out.volt_alarm || r_out.freq_alarm))
        else $error("total fault without a latched alarm");
`endif

endmodule

`default_nettype wire

>>> dv/lfs_alarm_checker.sv
// alarm checker: watches the config, sample and result channels, predicts and compares
`timescale 1ns / 1ps

module lfs_alarm_checker
    import lfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [VAL_W-1:0]      i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [OUT_DATA_W-1:0] i_out_data,
    output int                         o_errors,
    output int                         o_pending
);

    // bit offsets of the sample fields
    localparam int PHASE_BIT = 4;
    localparam int DEBUG_BIT = 5;
    localparam int FRST_BIT  = 6;
    localparam int START_BIT = 7;
    localparam int VOLT_LSB  = 8;
    localparam int FREQ_LSB  = 24;
    localparam int TEMP_LSB  = 40;
    localparam int NUM_TEMP  = 4;

    typedef struct packed {
        logic freq;
        logic volt;
        logic phase;
        logic temp;
        logic water;
        logic over_current;
    } t_latches;

    // limits and timing as last written
    logic [VAL_W-1:0]   volt_lo, volt_hi, freq_lo, freq_hi, temp_lo, temp_hi;
    logic [CNT_W-1:0]   stable_cfg;
    logic [DELAY_W-1:0] delay_cfg;

    // tick state
    logic                  seeded;
    logic [NUM_CH-1:0]     level;
    logic [CNT_W-1:0]      deb_cnt [NUM_CH];
    logic [HIGH_RUN_W-1:0] hi_run;
    logic [LOW_RUN_W-1:0]  lo_run;
    logic                  phase_flag;
    t_latches              latches;
    logic                  total;
    logic                  running;
    logic                  last_start;
    logic [DELAY_W-1:0]    start_elapsed;
    logic [BLINK_W-1:0]    blink_elapsed;
    logic                  led;

    t_result expected_alarms [$];
    t_result want;

    string field_name [RESULT_W] = '{
        "over_current_alarm", "water_press_alarm", "water_temp_alarm",
        "phase_loss_alarm", "volt_alarm", "freq_alarm", "any_fault",
        "run_led", "device_running"
    };

    function automatic logic out_of_range(input logic [VAL_W-1:0] v,
                                          input logic [VAL_W-1:0] lo,
                                          input logic [VAL_W-1:0] hi);
        return ((lo != '0) && (v < lo)) || ((hi != '0) && (v > hi));
    endfunction

    // one sample tick: updates the state and returns the alarm outputs
    function automatic t_result predict_tick(input logic [IN_DATA_W-1:0] d);
        logic [NUM_CH-1:0] raw;
        logic              ph, dbg, frst, st, armed, hot;
        logic [VAL_W-1:0]  volt, freq;
        logic [BLINK_W-1:0] interval;
        t_result           r;
        int                i;
        raw  = d[NUM_CH-1:0];
        ph   = d[PHASE_BIT];
        dbg  = d[DEBUG_BIT];
        frst = d[FRST_BIT];
        st   = d[START_BIT];
        volt = d[VOLT_LSB +: VAL_W];
        freq = d[FREQ_LSB +: VAL_W];

        // debounce and phase scan, first tick seeds the levels
        if (!seeded) begin
            level = raw;
            for (i = 0; i < NUM_CH; i++) deb_cnt[i] = '0;
            phase_flag = ph;
            seeded = 1'b1;
        end else begin
            for (i = 0; i < NUM_CH; i++) begin
                if (raw[i] == level[i]) begin
                    deb_cnt[i] = '0;
                end else begin
                    if (deb_cnt[i] != '1) deb_cnt[i] = deb_cnt[i] + 1'b1;
                    if (deb_cnt[i] >= stable_cfg) begin
                        level[i] = raw[i];
                        deb_cnt[i] = '0;
                    end
                end
            end
            if (ph) begin
                if (hi_run != '1) hi_run = hi_run + 1'b1;
                if (hi_run >= PHASE_SET_RUN) phase_flag = 1'b1;
                lo_run = '0;
            end else begin
                if (lo_run != '1) lo_run = lo_run + 1'b1;
                if (lo_run >= PHASE_CLEAR_RUN) phase_flag = 1'b0;
                hi_run = '0;
            end
        end

        // masked by debug or maintenance, otherwise latch the faults
        if (dbg || !level[CH_MAINT]) begin
            latches = '0;
            total = 1'b0;
        end else begin
            if (frst) latches = '0;
            running = level[CH_RUNNING];
            if (st && !last_start) start_elapsed = '0;
            last_start = st;
            armed = st && (start_elapsed >= delay_cfg);
            if (armed && out_of_range(volt, volt_lo, volt_hi)) latches.volt = 1'b1;
            if (armed && out_of_range(freq, freq_lo, freq_hi)) latches.freq = 1'b1;
            hot = 1'b0;
            for (i = 0; i < NUM_TEMP; i++)
                if (out_of_range(d[TEMP_LSB + VAL_W*i +: VAL_W], temp_lo, temp_hi)) hot = 1'b1;
            if (hot) latches.temp = 1'b1;
            if (level[CH_OVERCUR]) latches.over_current = 1'b1;
            if (level[CH_WATER]) latches.water = 1'b1;
            if (phase_flag) latches.phase = 1'b1;
            total = |latches;
        end

        // run led blink
        interval = total ? BLINK_FAULT : BLINK_NORMAL;
        if (blink_elapsed >= interval) begin
            blink_elapsed = '0;
            led = ~led;
        end

        r.over_current_alarm = latches.over_current;
        r.water_press_alarm  = latches.water;
        r.water_temp_alarm   = latches.temp;
        r.phase_loss_alarm   = latches.phase;
        r.volt_alarm         = latches.volt;
        r.freq_alarm         = latches.freq;
        r.any_fault          = total;
        r.run_led            = led;
        r.device_running     = running;

        // elapsed counters saturate
        if (start_elapsed != '1) start_elapsed = start_elapsed + 1'b1;
        if (blink_elapsed != '1) blink_elapsed = blink_elapsed + 1'b1;
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    // all three channels are sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            volt_lo = '0; volt_hi = '0; freq_lo = '0; freq_hi = '0;
            temp_lo = '0; temp_hi = '0;
            stable_cfg = STABLE_RESET;
            delay_cfg = DELAY_RESET;
            seeded = 1'b0;
            level = '0;
            for (int i = 0; i < NUM_CH; i++) deb_cnt[i] = '0;
            hi_run = '0;
            lo_run = '0;
            phase_flag = 1'b0;
            latches = '0;
            total = 1'b0;
            running = 1'b0;
            last_start = 1'b0;
            start_elapsed = '0;
            blink_elapsed = '0;
            led = 1'b0;
            expected_alarms.delete();
        end else begin
            // config register transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_index'(i_cfg_index))
                    REG_VOLT_LOW:     volt_lo = i_cfg_data;
                    REG_VOLT_HIGH:    volt_hi = i_cfg_data;
                    REG_FREQ_LOW:     freq_lo = i_cfg_data;
                    REG_FREQ_HIGH:    freq_hi = i_cfg_data;
                    REG_TEMP_LOW:     temp_lo = i_cfg_data;
                    REG_TEMP_HIGH:    temp_hi = i_cfg_data;
                    REG_STABLE_COUNT: stable_cfg = i_cfg_data[CNT_W-1:0];
                    REG_START_DELAY:  delay_cfg = i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_alarms.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = expected_alarms.pop_front();
                    for (int b = 0; b < RESULT_W; b++) begin
                        if (i_out_data[b] !== want[b]) begin
                            o_errors++;
                            $display("%0t: %s mismatch, expected %b, actual %b",
                                     $time, field_name[b], want[b], i_out_data[b]);
                        end
                    end
                    if (i_out_data[OUT_DATA_W-1:RESULT_W] !== '0) begin
                        o_errors++;
                        $display("%0t: fill bits mismatch, expected 0, actual %h",
                                 $time, i_out_data[OUT_DATA_W-1:RESULT_W]);
                    end
                end
            end

            // sample transfer
            if (i_in_valid && i_in_ready) expected_alarms.push_back(predict_tick(i_in_data));
        end
        o_pending = expected_alarms.size();
    end

endmodule

>>> dv/latched_fault_supervisor_tb.sv
// testbench top: clock, reset, sample and config stimulus, and the verdict
`timescale 1ns / 1ps

module latched_fault_supervisor_tb;
    import lfs_pkg::*;

    // sample fields, raw channels in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0]  temp_four;
        logic [VAL_W-1:0]  temp_three;
        logic [VAL_W-1:0]  temp_two;
        logic [VAL_W-1:0]  temp_one;
        logic [VAL_W-1:0]  work_freq;
        logic [VAL_W-1:0]  dc_voltage;
        logic              start_request;
        logic              fault_reset;
        logic              debug_mode;
        logic              phase_raw;
        logic [NUM_CH-1:0] raw_channels;
    } t_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [VAL_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int errors;
    int pending;

    // idling control
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold = 0;

    // limits currently programmed, used to aim the readings
    logic [VAL_W-1:0] cur_vl, cur_vh, cur_fl, cur_fh, cur_tl, cur_th;

    // random sequence state
    logic [NUM_CH-1:0] base_raw = '0;
    logic              start_level = 1'b0;
    logic              phase_level = 1'b0;
    int                seg_left = 0;
    int                phase_left = 0;

    always #2 i_clk = ~i_clk;

    latched_fault_supervisor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lfs_alarm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one sample transfer, entered and left at a falling edge
    task automatic send_sample(input t_sample s);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [NUM_CH-1:0] raw, input logic ph, dbg, frst, st,
                               input logic [VAL_W-1:0] volt, freq, t1, t2, t3, t4);
        t_sample s;
        s.raw_channels  = raw;
        s.phase_raw     = ph;
        s.debug_mode    = dbg;
        s.fault_reset   = frst;
        s.start_request = st;
        s.dc_voltage    = volt;
        s.work_freq     = freq;
        s.temp_one      = t1;
        s.temp_two      = t2;
        s.temp_three    = t3;
        s.temp_four     = t4;
        send_sample(s);
    endtask

    // stop sending, wait for every result, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // config register transfer, valid is left high for the next write
    task automatic write_reg(input t_reg_index idx, input logic [VAL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [VAL_W-1:0] vl, vh, fl, fh, tl, th,
                                 input logic [CNT_W-1:0] sc, input logic [DELAY_W-1:0] sd);
        write_reg(REG_VOLT_LOW, vl);
        write_reg(REG_VOLT_HIGH, vh);
        write_reg(REG_FREQ_LOW, fl);
        write_reg(REG_FREQ_HIGH, fh);
        write_reg(REG_TEMP_LOW, tl);
        write_reg(REG_TEMP_HIGH, th);
        write_reg(REG_STABLE_COUNT, VAL_W'(sc));
        write_reg(REG_START_DELAY, VAL_W'(sd));
        i_cfg_valid <= 1'b0;
        cur_vl = vl; cur_vh = vh;
        cur_fl = fl; cur_fh = fh;
        cur_tl = tl; cur_th = th;
    endtask

    // random limit pairs, now and then disabled
    task automatic apply_random_setting(input logic [CNT_W-1:0] sc,
                                        input logic [DELAY_W-1:0] sd);
        logic [VAL_W-1:0] lim [6];
        int k;
        for (k = 0; k < 6; k += 2) begin
            lim[k] = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(40000, 1));
            lim[k+1] = ($urandom_range(0, 5) == 0) ? 16'd0
                                                   : 16'(lim[k] + $urandom_range(25000, 0));
        end
        apply_setting(lim[0], lim[1], lim[2], lim[3], lim[4], lim[5], sc, sd);
    endtask

    // mostly inside the limits, sometimes on or just past an edge
    function automatic logic [VAL_W-1:0] pick_reading(input logic [VAL_W-1:0] lo, hi);
        int top_v;
        int k;
        top_v = (hi == '0) ? 65535 : hi;
        k = $urandom_range(0, 19);
        if (k == 0) return '0;
        if (k == 1) return '1;
        if (k == 2) return lo - 1'b1;
        if (k == 3) return hi + 1'b1;
        if (k == 4 || lo > top_v) return VAL_W'($urandom);
        return VAL_W'($urandom_range(top_v, lo));
    endfunction

    // held channel levels and start with glitches, phase pin in runs, some noise items
    task automatic run_random(input int count, input bit hold_start);
        t_sample      s;
        logic [127:0] noise;
        int           n;
        int           idx;
        for (n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                base_raw = NUM_CH'($urandom);
                base_raw[CH_MAINT] = ($urandom_range(0, 6) != 0);
                start_level = ($urandom_range(0, 4) != 0);
                seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            if (phase_left == 0) begin
                phase_level = 1'($urandom_range(0, 1));
                phase_left = phase_level ? $urandom_range(1, 6) : $urandom_range(1, 60);
            end
            phase_left--;
            if ($urandom_range(0, 9) == 0) begin
                noise = {$urandom, $urandom, $urandom, $urandom};
                s = noise[IN_DATA_W-1:0];
            end else begin
                s.raw_channels = base_raw;
                if ($urandom_range(0, 9) == 0) begin
                    idx = $urandom_range(0, NUM_CH - 1);
                    s.raw_channels[idx] = ~s.raw_channels[idx];
                end
                s.phase_raw     = ($urandom_range(0, 19) == 0) ? ~phase_level : phase_level;
                s.debug_mode    = ($urandom_range(0, 39) == 0);
                s.fault_reset   = ($urandom_range(0, 19) == 0);
                s.start_request = ($urandom_range(0, 49) == 0) ? ~start_level : start_level;
                s.dc_voltage    = pick_reading(cur_vl, cur_vh);
                s.work_freq     = pick_reading(cur_fl, cur_fh);
                s.temp_one      = pick_reading(cur_tl, cur_th);
                s.temp_two      = pick_reading(cur_tl, cur_th);
                s.temp_three    = pick_reading(cur_tl, cur_th);
                s.temp_four     = pick_reading(cur_tl, cur_th);
            end
            if (hold_start) s.start_request = 1'b1;
            send_sample(s);
        end
    endtask

    // hard stop
    initial begin
        #2_000_000;
        $display("latched_fault_supervisor_tb NOT OK");
        $finish;
    end

    initial begin
        cur_vl = '0; cur_vh = '0; cur_fl = '0; cur_fh = '0; cur_tl = '0; cur_th = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default limits: first tick seeds levels and phase, then reset and debug
        send_fields(4'b1111, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(4'b1111, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(4'b1111, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // narrow limits, one-sample debounce, checks right on the start edge
        apply_setting(16'd100, 16'd200, 16'd50, 16'd60, 16'd10, 16'd90, 4'd1, 9'd0);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b0, 16'd150, 16'd55, 16'd50, 16'd50,
                    16'd50, 16'd50);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'hFFFF, 16'd50, 16'd50,
                    16'd50, 16'd50);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd50,
                    16'd50, 16'd50);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b1, 16'd100, 16'd60, 16'd50, 16'd9,
                    16'd50, 16'd50);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b1, 16'd200, 16'd50, 16'd50, 16'd50,
                    16'd91, 16'd50);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b1, 16'd201, 16'd49, 16'd50, 16'd50,
                    16'd50, 16'hFFFF);
        send_fields(4'b0010, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b0, 1'b0, 16'd150, 16'd55, 16'd10, 16'd90,
                    16'd10, 16'd90);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b0, 1'b1, 16'd99, 16'd61, 16'd50, 16'd50,
                    16'd50, 16'd50);
        wait_drained();

        // extreme limits, zero stable count, one tick start delay
        apply_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 4'd0, 9'd1);
        send_fields(4'b1100, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(4'b1111, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                    16'hFFFF, 16'd0);
        send_fields(4'b1111, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'hFFFE, 16'd0, 16'd0,
                    16'd0, 16'd0);
        send_fields(4'b0011, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(4'b0011, 1'b1, 1'b0, 1'b0, 1'b1, 16'd5, 16'hFFFF, 16'd1, 16'd1,
                    16'd1, 16'd1);
        send_fields(4'b0011, 1'b1, 1'b0, 1'b0, 1'b1, 16'd5, 16'hFFFF, 16'd1, 16'd1,
                    16'd1, 16'd1);
        wait_drained();

        // random phases across several settings
        apply_random_setting(4'd3, 9'd20);
        run_random(45, 1'b0);
        wait_drained();

        rx_gaps = 1'b0;
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd15, 9'd1);
        run_random(45, 1'b0);
        wait_drained();

        rx_gaps = 1'b1;
        tx_gaps = 1'b0;
        apply_setting(16'd1, 16'hFFFE, 16'd1, 16'hFFFE, 16'd1, 16'hFFFE, 4'd1, 9'd0);
        run_random(45, 1'b0);
        wait_drained();

        tx_gaps = 1'b1;
        apply_random_setting(CNT_W'($urandom_range(1, 15)), DELAY_W'($urandom_range(1, 60)));
        run_random(45, 1'b0);
        wait_drained();

        // long held start: long delay and led blinking
        apply_random_setting(4'd2, 9'd300);
        run_random(330, 1'b1);
        wait_drained();

        // closing part without idling
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        apply_random_setting(4'd4, 9'd5);
        run_random(40, 1'b0);
        wait_drained();

        if (errors == 0) begin
            $display("latched_fault_supervisor_tb OK");
        end else begin
            $display("latched_fault_supervisor_tb NOT OK");
        end
        $finish;
    end

endmodule
